>>> hw/rtl/clap_rhythm_command_decoder_defines.svh
// assertion macros for the clap rhythm command decoder
`ifndef CLAP_RHYTHM_COMMAND_DECODER_DEFINES_SVH
`define CLAP_RHYTHM_COMMAND_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CRCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CRCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define CRCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hw/rtl/crcd_pkg.sv
// shared types and constants of the clap rhythm command decoder
package crcd_pkg;

  localparam int SLOT_MS_W   = 10;
  localparam int INTERVAL_W  = 16;
  localparam int AGE_W       = 13;
  localparam int MASK_W      = 5;
  localparam int POS_W       = 3;
  localparam int CMD_W       = 3;

  localparam logic [SLOT_MS_W-1:0] SLOT_MS_RESET = 10'd200;

  typedef enum logic [1:0] {
    OP_CLAP  = 2'd0,
    OP_TICK  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE     = 3'd0,
    CMD_POWER    = 3'd1,
    CMD_VOL_UP   = 3'd2,
    CMD_VOL_DOWN = 3'd3,
    CMD_CH_UP    = 3'd4,
    CMD_CH_DOWN  = 3'd5
  } cmd_t;

  // rhythm window state
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [POS_W-1:0]  position;
    logic [AGE_W-1:0]  age;
    cmd_t              prev;
  } win_state_t;

  typedef struct packed {
    cmd_t command;
    logic recognized;
  } result_t;

  localparam win_state_t WIN_STATE_RESET = '{
    mask: '0, position: '0, age: '0, prev: CMD_NONE
  };

endpackage

>>> hw/rtl/crcd_if.sv
// handshake channels of the clap rhythm command decoder
interface crcd_in_if import crcd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [1:0]            opcode;
  logic [INTERVAL_W-1:0] interval_ms;
  modport source (output valid, opcode, interval_ms, input ready);
  modport sink   (input valid, opcode, interval_ms, output ready);
endinterface

interface crcd_out_if import crcd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic             recognized;
  modport source (output valid, command, recognized, input ready);
  modport sink   (input valid, command, recognized, output ready);
endinterface

interface crcd_cfg_if import crcd_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [SLOT_MS_W-1:0] slot_ms;
  modport source (output valid, slot_ms, input ready);
  modport sink   (input valid, slot_ms, output ready);
endinterface

>>> hw/rtl/clap_rhythm_command_decoder.sv
// top level of the clap rhythm command decoder
//
//  channel | dir | payload                       | handshake
//  --------+-----+-------------------------------+-----------
//  in_ch   | in  | opcode, interval_ms           | valid/ready
//  out_ch  | out | command, recognized           | valid/ready
//  cfg_ch  | in  | slot_ms                       | valid/ready
//
// one word per cycle while the result is not stalled: input register, one pass of decode logic, result register
// each word gives exactly one result word, which waits in the result register until taken
// window state updates as a word moves into the result register
// a stalled result holds the result register; the input register then fills
// rst_n is synchronous: window cleared, slot_ms back to 200 ms
`include "clap_rhythm_command_decoder_defines.svh"

module clap_rhythm_command_decoder import crcd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  crcd_in_if.sink      in_ch,
  crcd_out_if.source   out_ch,
  crcd_cfg_if.sink     cfg_ch
);

  logic                  in_valid_r;
  logic [1:0]            in_op_r;
  logic [INTERVAL_W-1:0] in_int_r;
  logic                  out_valid_r;
  result_t               res_r;
  result_t               res_nxt;
  win_state_t            state_r;
  win_state_t            state_nxt;
  logic [SLOT_MS_W-1:0]  slot_ms_r;
  logic                  adv;
  logic                  in_ready;

  // handshake
  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ready     = !in_valid_r || adv;
  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  crcd_step u_step (
    .st          (state_r),
    .opcode      (in_op_r),
    .interval_ms (in_int_r),
    .slot_ms     (slot_ms_r),
    .st_nxt      (state_nxt),
    .res         (res_nxt)
  );

  // control, slot_ms config and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= WIN_STATE_RESET;
      slot_ms_r   <= SLOT_MS_RESET;
    end else begin
      if (cfg_ch.valid) begin
        slot_ms_r <= cfg_ch.slot_ms;
      end
      if (in_ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
      if (adv && in_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      in_op_r  <= in_ch.opcode;
      in_int_r <= in_ch.interval_ms;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (adv && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.command    = res_r.command;
  assign out_ch.recognized = res_r.recognized;

  // checks
  `CRCD_ASSERT_NOW(a_recog_matches_cmd, clk, rst_n, out_valid_r, (res_r.recognized == (res_r.command != CMD_NONE)), "recognized flag disagrees with command")
  `CRCD_ASSERT_NEXT(a_clear_on_recog, clk, rst_n, (adv && in_valid_r && res_nxt.recognized), (state_r.mask == '0), "window not cleared after recognition")
  `CRCD_ASSERT_NOW(a_pos_marked, clk, rst_n, (state_r.mask != '0), ((state_r.position <= 3'd4) && state_r.mask[state_r.position]), "latest clap slot not marked")
  `CRCD_ASSERT_NOW(a_power_not_kept, clk, rst_n, 1'b1, (state_r.prev != CMD_POWER), "power kept as repeatable command")

endmodule

>>> hw/rtl/crcd_step.sv
// next window state and result for one word
module crcd_step import crcd_pkg::*; (
  input  win_state_t            st,
  input  logic [1:0]            opcode,
  input  logic [INTERVAL_W-1:0] interval_ms,
  input  logic [SLOT_MS_W-1:0]  slot_ms,
  output win_state_t            st_nxt,
  output result_t               res
);

  logic [SLOT_MS_W:0]   lim2;
  logic [SLOT_MS_W+1:0] lim3;
  logic [AGE_W-1:0]     lim5;
  logic [2:0]           step;
  logic [POS_W:0]       pos_sum;
  logic                 aged;
  cmd_t                 matched;

  // slot multiples by shift and add
  assign lim2 = {slot_ms, 1'b0};
  assign lim3 = {1'b0, lim2} + {2'b0, slot_ms};
  assign lim5 = {1'b0, slot_ms, 2'b0} + {3'b0, slot_ms};

  // interval quantisation
  always_comb begin
    if (interval_ms <= {6'b0, slot_ms}) begin
      step = 3'd1;
    end else if (interval_ms <= {5'b0, lim2}) begin
      step = 3'd2;
    end else if (interval_ms <= {4'b0, lim3}) begin
      step = 3'd3;
    end else begin
      step = 3'd4;
    end
  end

  assign pos_sum = {1'b0, st.position} + {1'b0, step};
  assign aged    = (st.age >= lim5);

  // fixed rhythm table, bit i is slot i
  always_comb begin
    case (st.mask)
      5'h15:          matched = CMD_POWER;
      5'h0B, 5'h13:   matched = CMD_VOL_UP;
      5'h19, 5'h0D:   matched = CMD_VOL_DOWN;
      5'h11:          matched = CMD_CH_UP;
      5'h05, 5'h09:   matched = CMD_CH_DOWN;
      default:        matched = CMD_NONE;
    endcase
  end

  // state update and result
  always_comb begin
    st_nxt         = st;
    res.command    = CMD_NONE;
    res.recognized = 1'b0;
    case (op_t'(opcode))
      OP_CLAP: begin
        if ((interval_ms > {3'b0, lim5}) || (pos_sum >= 4'd5)) begin
          st_nxt.mask     = 5'b00001;
          st_nxt.position = '0;
          st_nxt.age      = '0;
        end else begin
          st_nxt.position = pos_sum[POS_W-1:0];
          st_nxt.mask     = st.mask | (MASK_W'(1) << pos_sum[POS_W-1:0]);
        end
      end
      OP_TICK: begin
        if (!aged) begin
          st_nxt.age = st.age + AGE_W'(1);
        end
      end
      OP_QUERY: begin
        if ((st.mask != '0) && aged) begin
          if ((st.mask == 5'b00001) && (st.prev != CMD_NONE)) begin
            st_nxt.mask     = '0;
            st_nxt.position = '0;
            st_nxt.age      = '0;
            res.command     = st.prev;
            res.recognized  = 1'b1;
          end else if (matched != CMD_NONE) begin
            st_nxt.mask     = '0;
            st_nxt.position = '0;
            st_nxt.age      = '0;
            st_nxt.prev     = (matched == CMD_POWER) ? CMD_NONE : matched;
            res.command     = matched;
            res.recognized  = 1'b1;
          end else begin
            st_nxt.prev = CMD_NONE;
          end
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

endmodule
